// ===== hw/rtl/ffha_pkg.sv =====
// shared types and constants for the first-fit heap allocator
// no dependencies; imported by the controller, datapath, top level and checker
package ffha_pkg;

  // fixed field widths of the request and response items
  localparam int REQ_W    = 13;
  localparam int OFS_W    = 12;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SPLIT,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                step;
    logic                wr_head;
    logic                wr_split;
    logic                finish;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_free;
    logic free_bad;
    logic fits;
    logic split;
    logic step_end;
    logic used;
    logic out_ready;
  } dp_sts_t;

endpackage

// ===== hw/rtl/ffha_ctrl.sv =====
// controller state machine of the first-fit heap allocator
// depends on ffha_pkg; drives the datapath through dp_cmd_t
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ffha_pkg::dp_sts_t sts,
  output ffha_pkg::dp_cmd_t cmd
);
  import ffha_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (!sts.req_free) begin
            state_next = S_SCAN;
          end else if (sts.free_bad) begin
            state_next = S_FINISH;
            code_next  = ST_IGNORED;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_SCAN: begin
        if (sts.fits) begin
          state_next = sts.split ? S_SPLIT : S_FINISH;
          code_next  = ST_DONE;
        end else if (sts.step_end) begin
          state_next = S_FINISH;
          code_next  = ST_NO_SPACE;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        code_next  = sts.used ? ST_DONE : ST_IGNORED;
      end
      S_SPLIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.code  = code;
    req_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_SCAN: begin
        if (sts.fits) begin
          cmd.wr_head = 1'b1;
        end else if (!sts.step_end) begin
          cmd.step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.wr_head = sts.used;
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = sts.out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ffha_datapath.sv =====
// datapath of the first-fit heap allocator: header memory, walk pointer, response register
// depends on ffha_pkg; commanded by ffha_ctrl
module ffha_datapath #(
  parameter int ARENA_UNITS  = 4096,
  parameter int HEADER_UNITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            operation,
  input  logic [ffha_pkg::REQ_W-1:0]      request_size,
  input  logic [ffha_pkg::OFS_W-1:0]      free_offset,
  input  ffha_pkg::dp_cmd_t               cmd,
  output ffha_pkg::dp_sts_t               sts,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ffha_pkg::STATUS_W-1:0]   status,
  output logic [ffha_pkg::OFS_W-1:0]      payload_offset
);
  import ffha_pkg::*;

  localparam int AW = $clog2(ARENA_UNITS);
  localparam int CW = ((AW > REQ_W) ? AW : REQ_W) + 2;
  localparam logic [CW-1:0] ARENA_C   = CW'(ARENA_UNITS);
  localparam logic [CW-1:0] HDR_C     = CW'(HEADER_UNITS);
  localparam logic [AW-1:0] INIT_SIZE = AW'(ARENA_UNITS - HEADER_UNITS);

  // entry: used flag on top, size magnitude below
  logic [AW:0] mem [0:ARENA_UNITS-1];

  logic [AW:0]      rd_data;
  logic             rd_zero;
  logic             zero_written;
  logic [AW-1:0]    pos;
  logic [REQ_W-1:0] want;
  logic             op;

  logic             head_used;
  logic [AW-1:0]    head_size;
  logic [CW-1:0]    size_c;
  logic [CW-1:0]    want_c;
  logic [CW-1:0]    pos_c;
  logic [CW-1:0]    next_c;
  logic [CW-1:0]    rest_c;
  logic [CW-1:0]    rest_size;
  logic [CW-1:0]    where_c;
  logic [CW-1:0]    start_c;
  logic [CW-1:0]    payload_c;
  logic             free_bad;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW:0]      wr_data;

  // offset 0 reads as the whole free arena until it is first written
  assign head_used = rd_zero ? 1'b0 : rd_data[AW];
  assign head_size = rd_zero ? INIT_SIZE : rd_data[AW-1:0];

  assign size_c    = CW'(head_size);
  assign want_c    = CW'(want);
  assign pos_c     = CW'(pos);
  assign next_c    = pos_c + HDR_C + size_c;
  assign rest_c    = pos_c + HDR_C + want_c;
  assign rest_size = size_c - HDR_C - want_c;
  assign payload_c = pos_c + HDR_C;

  assign where_c  = CW'(free_offset);
  assign free_bad = (where_c < HDR_C) || ((where_c - HDR_C) >= ARENA_C);
  assign start_c  = (operation == OP_FREE && !free_bad) ? (where_c - HDR_C) : '0;

  assign rd_en   = cmd.load || cmd.step;
  assign rd_addr = cmd.load ? start_c[AW-1:0] : next_c[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = {1'b0, head_size};
    if (cmd.wr_split) begin
      wr_en   = (rest_c < ARENA_C);
      wr_addr = rest_c[AW-1:0];
      wr_data = {1'b0, rest_size[AW-1:0]};
    end else if (cmd.wr_head) begin
      wr_en = 1'b1;
      if (op == OP_ALLOC) begin
        wr_data = {1'b1, sts.split ? want_c[AW-1:0] : head_size};
      end
    end
  end

  always_comb begin
    sts.req_free  = (operation == OP_FREE);
    sts.free_bad  = free_bad;
    sts.fits      = !head_used && (size_c >= want_c);
    sts.split     = (size_c > (want_c + HDR_C));
    sts.step_end  = (next_c >= ARENA_C);
    sts.used      = head_used;
    sts.out_ready = !rsp_valid || !rsp_stall;
  end

  // header memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_zero <= (rd_addr == '0) && !zero_written;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos  <= start_c[AW-1:0];
      want <= request_size;
      op   <= operation;
    end else if (cmd.step) begin
      pos <= next_c[AW-1:0];
    end
    if (cmd.finish) begin
      status         <= cmd.code;
      payload_offset <= (cmd.code == ST_DONE && op == OP_ALLOC) ? payload_c[OFS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      zero_written <= 1'b0;
    end else begin
      if (wr_en && wr_addr == '0) begin
        zero_written <= 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// top level of the first-fit heap allocator
// depends on ffha_pkg, ffha_ctrl and ffha_datapath
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req     | in        | req_valid, req_stall | operation, request_size, free_offset
//   rsp     | out       | rsp_valid, rsp_stall | status, payload_offset
//
// an allocate goes through accept, one header visit per chunk header walked, a split write
// when the chosen chunk is split, then response load; the walk reads one header at a time
// a free goes through accept, header read and update, response load; a null, below-header
// or past-arena free goes through accept, response load
// reset (rst, synchronous) empties the response register and makes the arena one free
// chunk; offset 0 reads as that chunk until written, so no clearing pass is needed
// req_stall is high while an item is in flight; a new item is accepted while the
// previous response still waits under rsp_stall, the response register parting the two;
// the response load cycle repeats until the previous response has been taken
module first_fit_heap_allocator_unit #(
  parameter int ARENA_UNITS  = 4096,
  parameter int HEADER_UNITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          operation,
  input  logic [ffha_pkg::REQ_W-1:0]    request_size,
  input  logic [ffha_pkg::OFS_W-1:0]    free_offset,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ffha_pkg::STATUS_W-1:0] status,
  output logic [ffha_pkg::OFS_W-1:0]    payload_offset
);
  import ffha_pkg::*;

  // command and status between the state machine and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, header walk, free header check, split write, response load
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // header memory, walk pointer, size compares and the response register
  ffha_datapath #(
    .ARENA_UNITS  (ARENA_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .request_size   (request_size),
    .free_offset    (free_offset),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .payload_offset (payload_offset)
  );

endmodule

// ===== hw/rtl/ffha_checker.sv =====
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator_unit
module ffha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [ffha_pkg::STATUS_W-1:0] status,
  input logic [ffha_pkg::OFS_W-1:0]    payload_offset
);
  import ffha_pkg::*;

  // an accepted item blocks the request side on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request side open right after an accepted item");

  // a response only appears while an item is in flight
  a_rsp_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without an item in flight");

  // only successful items carry an offset, and the code is a known one
  a_status_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_DONE) |-> (payload_offset == '0 &&
      (status == ST_NO_SPACE || status == ST_IGNORED)))
    else $error("bad status or stray offset on response");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(payload_offset)))
    else $error("stalled response changed");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .payload_offset (payload_offset)
);
